@@ src/graph_bfs_dfs_traversal_defines.svh @@
// ----------------------------------------------------------------------------
// Graph traversal assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_DFS_TRAVERSAL_DEFINES_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_DEFINES_SVH

// checked outside reset
`define GBDT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gbdt assertion failed");

// checked on every edge
`define GBDT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("gbdt assertion failed");

`endif

@@ src/gbdt_pkg.sv @@
// ----------------------------------------------------------------------------
// gbdt_pkg
// Types and codes shared by the graph traversal controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gbdt_pkg;

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_BFS = 2'd1;
   localparam logic [1:0] FUNC_DFS = 2'd2;

   localparam logic [1:0] VIS_NEW  = 2'd0;
   localparam logic [1:0] VIS_OPEN = 2'd1;
   localparam logic [1:0] VIS_DONE = 2'd2;

   localparam int FIELD_VERTICES = 32;
   localparam logic [5:0] VCOUNT_RESET = 6'd32;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_T_OUTER, S_B_POP, S_B_SCAN, S_B_CHK, S_B_EMIT,
      S_D_START, S_D_TOP, S_D_SCAN, S_D_CHK, S_D_PUSH, S_FLUSH,
      S_E_SCAN, S_E_CMP, S_E_WF, S_E_WT, S_E_RES, S_E_REJ
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_TSTART, OP_I_INC, OP_BFS_SEED, OP_BFS_POP,
      OP_BFS_RD, OP_BFS_CHK, OP_BFS_EMIT, OP_DFS_SEED, OP_DFS_TOP, OP_DFS_RD,
      OP_DFS_POP, OP_DFS_PUSH, OP_FLUSH, OP_EDGE_RD, OP_EDGE_WF, OP_EDGE_WT,
      OP_EDGE_ACK, OP_EDGE_NAK
   } op_type;

   typedef enum logic [1:0] {CS_V, CS_F, CS_T} cnt_sel_type;
   typedef enum logic {VS_I, VS_W} vis_sel_type;

   typedef struct packed {
      op_type      op;
      cnt_sel_type cnt_sel;
      vis_sel_type vis_sel;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       edge_ok;
      logic       start_ok;
      logic       i_lt_n;
      logic       vis_done;
      logic       vis_new;
      logic       w_in_range;
      logic       head_lt_tail;
      logic       p_lt_cnt;
      logic       scan_lt_cnt;
      logic       tail_nz;
      logic       dup_hit;
      logic       can_emit;
      logic       rsp_free;
      logic       flush_ok;
   } status_type;

endpackage

`default_nettype wire

@@ src/gbdt_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbdt_ctrl
// Sequencer for edge insertion and breadth/depth-first traversal.
// ----------------------------------------------------------------------------
`default_nettype none

module gbdt_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  gbdt_pkg::status_type  status,
   output gbdt_pkg::cmd_type     cmd
);

   gbdt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbdt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gbdt_pkg::S_IDLE: begin
            if (req_tvalid) state_in = gbdt_pkg::S_DECODE;
         end
         gbdt_pkg::S_DECODE: begin
            if (status.func == gbdt_pkg::FUNC_ADD) begin
               state_in = status.edge_ok ? gbdt_pkg::S_E_SCAN : gbdt_pkg::S_E_REJ;
            end else if ((status.func == gbdt_pkg::FUNC_BFS ||
                          status.func == gbdt_pkg::FUNC_DFS) && status.start_ok) begin
               state_in = gbdt_pkg::S_T_OUTER;
            end else begin
               state_in = gbdt_pkg::S_IDLE;
            end
         end
         gbdt_pkg::S_T_OUTER: begin
            if (!status.i_lt_n) begin
               state_in = gbdt_pkg::S_FLUSH;
            end else if (status.func == gbdt_pkg::FUNC_BFS) begin
               if (!status.vis_done) state_in = gbdt_pkg::S_B_POP;
            end else if (status.vis_new) begin
               state_in = gbdt_pkg::S_D_START;
            end
         end
         gbdt_pkg::S_B_POP: begin
            state_in = status.head_lt_tail ? gbdt_pkg::S_B_SCAN : gbdt_pkg::S_T_OUTER;
         end
         gbdt_pkg::S_B_SCAN: begin
            state_in = status.p_lt_cnt ? gbdt_pkg::S_B_CHK : gbdt_pkg::S_B_EMIT;
         end
         gbdt_pkg::S_B_CHK:  state_in = gbdt_pkg::S_B_SCAN;
         gbdt_pkg::S_B_EMIT: begin
            if (status.can_emit) state_in = gbdt_pkg::S_B_POP;
         end
         gbdt_pkg::S_D_START: begin
            if (status.can_emit) state_in = gbdt_pkg::S_D_TOP;
         end
         gbdt_pkg::S_D_TOP: begin
            state_in = status.tail_nz ? gbdt_pkg::S_D_SCAN : gbdt_pkg::S_T_OUTER;
         end
         gbdt_pkg::S_D_SCAN: begin
            state_in = status.scan_lt_cnt ? gbdt_pkg::S_D_CHK : gbdt_pkg::S_D_TOP;
         end
         gbdt_pkg::S_D_CHK: begin
            state_in = (status.w_in_range && status.vis_new) ? gbdt_pkg::S_D_PUSH
                                                             : gbdt_pkg::S_D_TOP;
         end
         gbdt_pkg::S_D_PUSH: begin
            if (status.can_emit) state_in = gbdt_pkg::S_D_TOP;
         end
         gbdt_pkg::S_FLUSH: begin
            if (status.flush_ok) state_in = gbdt_pkg::S_IDLE;
         end
         gbdt_pkg::S_E_SCAN: begin
            state_in = status.p_lt_cnt ? gbdt_pkg::S_E_CMP : gbdt_pkg::S_E_WF;
         end
         gbdt_pkg::S_E_CMP: begin
            state_in = status.dup_hit ? gbdt_pkg::S_E_REJ : gbdt_pkg::S_E_SCAN;
         end
         gbdt_pkg::S_E_WF: state_in = gbdt_pkg::S_E_WT;
         gbdt_pkg::S_E_WT: state_in = gbdt_pkg::S_E_RES;
         gbdt_pkg::S_E_RES, gbdt_pkg::S_E_REJ: begin
            if (status.rsp_free) state_in = gbdt_pkg::S_IDLE;
         end
         default: state_in = gbdt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.op      = gbdt_pkg::OP_NONE;
      cmd.cnt_sel = gbdt_pkg::CS_V;
      cmd.vis_sel = gbdt_pkg::VS_W;
      case (state_ff)
         gbdt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = gbdt_pkg::OP_ACCEPT;
         end
         gbdt_pkg::S_DECODE: begin
            if ((status.func == gbdt_pkg::FUNC_BFS || status.func == gbdt_pkg::FUNC_DFS)
                && status.start_ok) cmd.op = gbdt_pkg::OP_TSTART;
         end
         gbdt_pkg::S_T_OUTER: begin
            cmd.vis_sel = gbdt_pkg::VS_I;
            if (status.i_lt_n) begin
               if (status.func == gbdt_pkg::FUNC_BFS) begin
                  cmd.op = status.vis_done ? gbdt_pkg::OP_I_INC : gbdt_pkg::OP_BFS_SEED;
               end else if (!status.vis_new) begin
                  cmd.op = gbdt_pkg::OP_I_INC;
               end
            end
         end
         gbdt_pkg::S_B_POP: begin
            cmd.op = status.head_lt_tail ? gbdt_pkg::OP_BFS_POP : gbdt_pkg::OP_I_INC;
         end
         gbdt_pkg::S_B_SCAN: begin
            if (status.p_lt_cnt) cmd.op = gbdt_pkg::OP_BFS_RD;
         end
         gbdt_pkg::S_B_CHK:  cmd.op = gbdt_pkg::OP_BFS_CHK;
         gbdt_pkg::S_B_EMIT: begin
            if (status.can_emit) cmd.op = gbdt_pkg::OP_BFS_EMIT;
         end
         gbdt_pkg::S_D_START: begin
            if (status.can_emit) cmd.op = gbdt_pkg::OP_DFS_SEED;
         end
         gbdt_pkg::S_D_TOP: begin
            cmd.op = status.tail_nz ? gbdt_pkg::OP_DFS_TOP : gbdt_pkg::OP_I_INC;
         end
         gbdt_pkg::S_D_SCAN: begin
            cmd.op = status.scan_lt_cnt ? gbdt_pkg::OP_DFS_RD : gbdt_pkg::OP_DFS_POP;
         end
         gbdt_pkg::S_D_PUSH: begin
            if (status.can_emit) cmd.op = gbdt_pkg::OP_DFS_PUSH;
         end
         gbdt_pkg::S_FLUSH: begin
            if (status.flush_ok) cmd.op = gbdt_pkg::OP_FLUSH;
         end
         gbdt_pkg::S_E_SCAN: begin
            cmd.cnt_sel = gbdt_pkg::CS_F;
            if (status.p_lt_cnt) cmd.op = gbdt_pkg::OP_EDGE_RD;
         end
         gbdt_pkg::S_E_WF: begin
            cmd.cnt_sel = gbdt_pkg::CS_F;
            cmd.op      = gbdt_pkg::OP_EDGE_WF;
         end
         gbdt_pkg::S_E_WT: begin
            cmd.cnt_sel = gbdt_pkg::CS_T;
            cmd.op      = gbdt_pkg::OP_EDGE_WT;
         end
         gbdt_pkg::S_E_RES: begin
            if (status.rsp_free) cmd.op = gbdt_pkg::OP_EDGE_ACK;
         end
         gbdt_pkg::S_E_REJ: begin
            if (status.rsp_free) cmd.op = gbdt_pkg::OP_EDGE_NAK;
         end
         default: cmd.op = gbdt_pkg::OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

@@ src/gbdt_dpath.sv @@
// ----------------------------------------------------------------------------
// gbdt_dpath
// Adjacency store, visit marks, work list and response staging.
// ----------------------------------------------------------------------------
`default_nettype none

module gbdt_dpath #(
   parameter int MAX_VERTICES = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [15:0]           req_tdata,
   input  wire                   csr_we,
   input  wire  [5:0]            csr_wdata,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   input  gbdt_pkg::cmd_type     cmd,
   output gbdt_pkg::status_type  status
);

   localparam int VCAP = (MAX_VERTICES < gbdt_pkg::FIELD_VERTICES) ?
                         MAX_VERTICES : gbdt_pkg::FIELD_VERTICES;
   localparam int IW   = $clog2(VCAP);
   localparam int CW   = $clog2(VCAP + 1);
   localparam int AW   = 2 * IW;

   logic [5:0]    vcount_ff;
   logic [1:0]    func_ff;
   logic [4:0]    from_ff, to_ff;
   logic [CW-1:0] i_ff, head_ff, tail_ff;
   logic [IW-1:0] v_ff, p_ff;
   logic [IW-1:0] rd_ff;
   logic [IW-1:0] cnt_ff [VCAP];
   logic [1:0]    visit_ff [VCAP];
   logic [IW-1:0] wl_ff [VCAP];
   logic [IW-1:0] scan_ff [VCAP];
   logic [IW-1:0] mem [2**AW];

   logic          pend_valid_ff;
   logic [IW-1:0] pend_ff;
   logic          rsp_valid_ff, rsp_last_ff, rsp_added_ff;
   logic [4:0]    rsp_vertex_ff;

   logic [5:0]    n;
   logic [IW-1:0] f_idx, t_idx, i_idx, cnt_addr, vis_addr, cnt_rd, scan_rd, wl_rd;
   logic [1:0]    vis_rd;
   logic          rsp_free, can_emit, w_ok;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [IW-1:0] mem_wdata;
   logic          mem_re;
   logic          emit;
   logic [IW-1:0] emit_v;
   logic          rsp_load;

   assign n     = (vcount_ff > 6'(VCAP)) ? 6'(VCAP) : vcount_ff;
   assign f_idx = IW'(from_ff);
   assign t_idx = IW'(to_ff);
   assign i_idx = IW'(i_ff);

   always_comb begin
      case (cmd.cnt_sel)
         gbdt_pkg::CS_F: cnt_addr = f_idx;
         gbdt_pkg::CS_T: cnt_addr = t_idx;
         default:        cnt_addr = v_ff;
      endcase
   end

   assign vis_addr = (cmd.vis_sel == gbdt_pkg::VS_I) ? i_idx : rd_ff;
   assign cnt_rd   = cnt_ff[cnt_addr];
   assign vis_rd   = visit_ff[vis_addr];
   assign scan_rd  = scan_ff[v_ff];
   assign wl_rd    = (func_ff == gbdt_pkg::FUNC_BFS) ? wl_ff[IW'(head_ff)]
                                                     : wl_ff[IW'(tail_ff - 1'b1)];
   assign w_ok     = 6'(rd_ff) < n;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign can_emit = !pend_valid_ff || rsp_free;
   assign rsp_load = ((emit || cmd.op == gbdt_pkg::OP_FLUSH) && pend_valid_ff) ||
                     cmd.op == gbdt_pkg::OP_EDGE_ACK || cmd.op == gbdt_pkg::OP_EDGE_NAK;

   always_comb begin
      status.func         = func_ff;
      status.edge_ok      = ({1'b0, from_ff} < n) && ({1'b0, to_ff} < n) &&
                            (from_ff != to_ff);
      status.start_ok     = {1'b0, from_ff} < n;
      status.i_lt_n       = 6'(i_ff) < n;
      status.vis_done     = vis_rd == gbdt_pkg::VIS_DONE;
      status.vis_new      = vis_rd == gbdt_pkg::VIS_NEW;
      status.w_in_range   = w_ok;
      status.head_lt_tail = head_ff < tail_ff;
      status.p_lt_cnt     = p_ff < cnt_rd;
      status.scan_lt_cnt  = scan_rd < cnt_rd;
      status.tail_nz      = tail_ff != '0;
      status.dup_hit      = rd_ff == t_idx;
      status.can_emit     = can_emit;
      status.rsp_free     = rsp_free;
      status.flush_ok     = !pend_valid_ff || rsp_free;
   end

   // neighbor table port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {f_idx, cnt_rd};
      mem_wdata = t_idx;
      mem_re    = 1'b0;
      mem_raddr = {v_ff, IW'(cnt_rd - 1'b1 - p_ff)};
      case (cmd.op)
         gbdt_pkg::OP_BFS_RD: mem_re = 1'b1;
         gbdt_pkg::OP_DFS_RD: begin
            mem_re    = 1'b1;
            mem_raddr = {v_ff, IW'(cnt_rd - 1'b1 - scan_rd)};
         end
         gbdt_pkg::OP_EDGE_RD: begin
            mem_re    = 1'b1;
            mem_raddr = {f_idx, p_ff};
         end
         gbdt_pkg::OP_EDGE_WF: mem_we = 1'b1;
         gbdt_pkg::OP_EDGE_WT: begin
            mem_we    = 1'b1;
            mem_waddr = {t_idx, cnt_rd};
            mem_wdata = f_idx;
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_ff <= mem[mem_raddr];
   end

   always_comb begin
      emit   = 1'b0;
      emit_v = v_ff;
      case (cmd.op)
         gbdt_pkg::OP_BFS_EMIT: emit = 1'b1;
         gbdt_pkg::OP_DFS_SEED: begin
            emit   = 1'b1;
            emit_v = i_idx;
         end
         gbdt_pkg::OP_DFS_PUSH: begin
            emit   = 1'b1;
            emit_v = rd_ff;
         end
         default: emit = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff     <= gbdt_pkg::VCOUNT_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < VCAP; k++) cnt_ff[k] <= '0;
      end else begin
         if (csr_we) vcount_ff <= csr_wdata;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (emit) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.op == gbdt_pkg::OP_FLUSH) begin
            pend_valid_ff <= 1'b0;
         end
         if (cmd.op == gbdt_pkg::OP_EDGE_WF || cmd.op == gbdt_pkg::OP_EDGE_WT)
            cnt_ff[cnt_addr] <= cnt_rd + 1'b1;
      end
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      if (emit) begin
         pend_ff <= emit_v;
         if (pend_valid_ff) begin
            rsp_vertex_ff <= 5'(pend_ff);
            rsp_added_ff  <= 1'b0;
            rsp_last_ff   <= 1'b0;
         end
      end
      case (cmd.op)
         gbdt_pkg::OP_ACCEPT: begin
            func_ff <= req_tdata[1:0];
            from_ff <= req_tdata[6:2];
            to_ff   <= req_tdata[11:7];
            p_ff    <= '0;
         end
         gbdt_pkg::OP_TSTART: begin
            i_ff <= CW'(from_ff);
            for (int k = 0; k < VCAP; k++) visit_ff[k] <= gbdt_pkg::VIS_NEW;
         end
         gbdt_pkg::OP_I_INC: i_ff <= i_ff + 1'b1;
         gbdt_pkg::OP_BFS_SEED: begin
            head_ff         <= '0;
            tail_ff         <= CW'(1);
            wl_ff[0]        <= i_idx;
            visit_ff[i_idx] <= gbdt_pkg::VIS_DONE;
         end
         gbdt_pkg::OP_BFS_POP: begin
            v_ff    <= wl_rd;
            head_ff <= head_ff + 1'b1;
            p_ff    <= '0;
         end
         gbdt_pkg::OP_BFS_RD: p_ff <= p_ff + 1'b1;
         gbdt_pkg::OP_BFS_CHK: begin
            if (w_ok && vis_rd != gbdt_pkg::VIS_DONE) begin
               wl_ff[IW'(tail_ff)] <= rd_ff;
               tail_ff             <= tail_ff + 1'b1;
               visit_ff[rd_ff]     <= gbdt_pkg::VIS_DONE;
            end
         end
         gbdt_pkg::OP_DFS_SEED: begin
            visit_ff[i_idx] <= gbdt_pkg::VIS_OPEN;
            scan_ff[i_idx]  <= '0;
            wl_ff[0]        <= i_idx;
            tail_ff         <= CW'(1);
         end
         gbdt_pkg::OP_DFS_TOP: v_ff <= wl_rd;
         gbdt_pkg::OP_DFS_RD:  scan_ff[v_ff] <= scan_rd + 1'b1;
         gbdt_pkg::OP_DFS_POP: begin
            visit_ff[v_ff] <= gbdt_pkg::VIS_DONE;
            tail_ff        <= tail_ff - 1'b1;
         end
         gbdt_pkg::OP_DFS_PUSH: begin
            visit_ff[rd_ff]     <= gbdt_pkg::VIS_OPEN;
            scan_ff[rd_ff]      <= '0;
            wl_ff[IW'(tail_ff)] <= rd_ff;
            tail_ff             <= tail_ff + 1'b1;
         end
         gbdt_pkg::OP_FLUSH: begin
            rsp_vertex_ff <= 5'(pend_ff);
            rsp_added_ff  <= 1'b0;
            rsp_last_ff   <= 1'b1;
         end
         gbdt_pkg::OP_EDGE_RD: p_ff <= p_ff + 1'b1;
         gbdt_pkg::OP_EDGE_ACK, gbdt_pkg::OP_EDGE_NAK: begin
            rsp_vertex_ff <= '0;
            rsp_added_ff  <= cmd.op == gbdt_pkg::OP_EDGE_ACK;
            rsp_last_ff   <= 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_vertex_ff, rsp_added_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

@@ src/graph_bfs_dfs_traversal.sv @@
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal
// Undirected graph store with breadth-first and depth-first traversal.
// ----------------------------------------------------------------------------
// One request at a time. An add-edge request returns its one response after
// a scan of the from-vertex's neighbor slots and its two table writes, with
// no scan when an endpoint is out of range or both are equal, and as soon as
// a duplicate is found. A traversal returns one response per visited vertex.
// It steps through each vertex index from the start up to the vertex count
// and scans the stored neighbor slots of each visited vertex through the
// neighbor table's registered read; each emitted vertex also waits while the
// output register is full. A response waiting on rsp_tready does not hold
// the next request off. No clearing pass.
`default_nettype none

module graph_bfs_dfs_traversal #(
   parameter int MAX_VERTICES = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // func[1:0], from_vertex[6:2], to_vertex[11:7]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // edge_added[0], visited_vertex[5:1]
   output logic        rsp_tlast,
   input  wire         csr_we,
   input  wire  [5:0]  csr_wdata    // vertex_count
);

   gbdt_pkg::cmd_type    cmd;
   gbdt_pkg::status_type status;

   gbdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gbdt_dpath #(.MAX_VERTICES(MAX_VERTICES)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

@@ src/gbdt_checker.sv @@
// ----------------------------------------------------------------------------
// gbdt_checker
// Port-level assertions for the graph traversal block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "graph_bfs_dfs_traversal_defines.svh"

module gbdt_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [7:0]  rsp_tdata,
   input wire        rsp_tlast
);

   `GBDT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `GBDT_ASSERT(a_added_last, clock, reset, rsp_tvalid && rsp_tdata[0] |-> rsp_tlast)
   `GBDT_ASSERT(a_added_novert, clock, reset, rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[5:1] == 5'd0)
   `GBDT_ASSERT(a_busy_after_req, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `GBDT_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid)

endmodule

bind graph_bfs_dfs_traversal gbdt_checker u_gbdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
